[src/rceg_pkg.sv]
// shared types, constants and the rise table for the cosine envelope generator
package rceg_pkg;

   localparam int COS_DEPTH = 1024;
   localparam int IDX_W = $clog2(COS_DEPTH) + 1;
   localparam int FRAME_W = 16;
   localparam int REPS_W = 7;
   localparam int PER_W = FRAME_W + 1;
   localparam int WEIGHT_W = 18;
   localparam int TAB_W = 17;
   localparam int NUM_W = PER_W;
   localparam int DEN_W = PER_W + 1;
   localparam int DIVD_W = NUM_W + IDX_W;
   localparam int QUO_W = REPS_W;
   localparam int MAX_REPS = 100;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int PHI_SH = $clog2(2 * COS_DEPTH);
   localparam int TERM_DIV_W = 34;

   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam longint unsigned ONE_Q16 = 64'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SPAN_START = 4'd0,
      REG_SPAN_END = 4'd1,
      REG_PEAK_FRAME = 4'd2,
      REG_TOTAL_FRAMES = 4'd3,
      REG_REPEAT_COUNT = 4'd4,
      REG_MIRROR_POSITION = 4'd5,
      REG_MIRROR_SIGN = 4'd6,
      REG_HALF_OFFSET = 4'd7
   } csr_addr_type;

   typedef enum logic [1:0] {
      CFG_LOAD,
      CFG_DIV,
      CFG_MUL,
      CFG_IDLE
   } cfg_state_type;

   typedef enum logic [2:0] {
      K_ZERO,
      K_ONE,
      K_NEG_ONE,
      K_HALF,
      K_PLAIN,
      K_SIGNED
   } kind_type;

   typedef struct packed {
      logic [FRAME_W-1:0] span_start;
      logic [FRAME_W-1:0] span_end;
      logic [FRAME_W-1:0] peak_frame;
      logic [FRAME_W-1:0] total_frames;
      logic [REPS_W-1:0] repeat_count;
      logic mirror_position;
      logic mirror_sign;
      logic half_offset;
      logic [PER_W-1:0] period;
      logic [PER_W-1:0] rep_total;
      logic err;
   } cfg_type;

   typedef struct packed {
      kind_type kind;
      logic minus;
      logic div2;
      logic err;
      logic oot;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } job_type;

   typedef logic [TAB_W-1:0] rise_tab_type [0:COS_DEPTH];

   // shift and subtract quotient, dividend below 2**TERM_DIV_W
   function automatic longint unsigned udiv_small(longint unsigned a, longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = TERM_DIV_W - 1; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic longint unsigned sine_q30(longint unsigned phi);
      longint unsigned p2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned dv;
      p2 = (phi * phi) >> 30;
      term = phi;
      sum = phi;
      for (int n = 1; n <= 8; n++) begin
         dv = longint'(2 * n) * longint'(2 * n + 1);
         term = udiv_small((term * p2) >> 30, dv);
         if ((n & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      return sum;
   endfunction

   function automatic rise_tab_type build_rise_tab();
      rise_tab_type tab;
      longint unsigned phi;
      longint unsigned s;
      longint unsigned w;
      for (int k = 0; k <= COS_DEPTH; k++) begin
         phi = (PI_Q30 * longint'(k)) >> PHI_SH;
         s = sine_q30(phi);
         w = (s * s + (64'd1 << 43)) >> 44;
         if (w > ONE_Q16) begin
            w = ONE_Q16;
         end
         tab[k] = w[TAB_W-1:0];
      end
      return tab;
   endfunction

endpackage

[src/rceg_cfg.sv]
// configuration registers and the derived period computed after each write
module rceg_cfg (
   input  logic clock,
   input  logic reset,
   input  logic csr_tvalid,
   output logic csr_tready,
   input  logic [rceg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rceg_pkg::CSR_DATA_W-1:0] csr_data,
   output rceg_pkg::cfg_type cfg,
   output logic busy
);
   import rceg_pkg::*;

   logic [FRAME_W-1:0] start_ff, end_ff, peak_ff, total_ff;
   logic [REPS_W-1:0] reps_ff;
   logic mpos_ff, msign_ff, half_ff;
   cfg_state_type state_ff, state_in;
   logic [4:0] cnt_ff;
   logic [PER_W-1:0] quo_ff, per_ff, rp_ff;
   logic [PER_W:0] rem_ff;
   logic [PER_W:0] rem_sh;
   logic [PER_W:0] reps_ext;
   logic do_load, do_div, do_mul;
   logic wr;
   logic [PER_W-1:0] numframe;
   logic [PER_W+REPS_W-1:0] prod;

   assign csr_tready = 1'b1;
   assign wr = csr_tvalid;
   assign numframe = {1'b0, end_ff} - {1'b0, start_ff} + PER_W'(1);
   assign reps_ext = {{(PER_W+1-REPS_W){1'b0}}, reps_ff};
   assign rem_sh = {rem_ff[PER_W-1:0], quo_ff[PER_W-1]};
   assign prod = quo_ff * reps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff <= '0;
         peak_ff <= '0;
         total_ff <= FRAME_W'(1);
         reps_ff <= REPS_W'(1);
         mpos_ff <= 1'b0;
         msign_ff <= 1'b0;
         half_ff <= 1'b0;
      end else if (wr) begin
         case (csr_addr_type'(csr_index))
            REG_SPAN_START: start_ff <= csr_data[FRAME_W-1:0];
            REG_SPAN_END: end_ff <= csr_data[FRAME_W-1:0];
            REG_PEAK_FRAME: peak_ff <= csr_data[FRAME_W-1:0];
            REG_TOTAL_FRAMES: total_ff <= csr_data[FRAME_W-1:0];
            REG_REPEAT_COUNT: reps_ff <= csr_data[REPS_W-1:0];
            REG_MIRROR_POSITION: mpos_ff <= csr_data[0];
            REG_MIRROR_SIGN: msign_ff <= csr_data[0];
            REG_HALF_OFFSET: half_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (wr) begin
         state_in = CFG_LOAD;
      end else begin
         case (state_ff)
            CFG_LOAD: state_in = CFG_DIV;
            CFG_DIV: state_in = (cnt_ff == 5'd0) ? CFG_MUL : CFG_DIV;
            CFG_MUL: state_in = CFG_IDLE;
            CFG_IDLE: state_in = CFG_IDLE;
            default: state_in = CFG_LOAD;
         endcase
      end
   end

   always_comb begin
      do_load = 1'b0;
      do_div = 1'b0;
      do_mul = 1'b0;
      busy = 1'b1;
      case (state_ff)
         CFG_LOAD: do_load = 1'b1;
         CFG_DIV: do_div = 1'b1;
         CFG_MUL: do_mul = 1'b1;
         CFG_IDLE: busy = 1'b0;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CFG_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // restoring divider: one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (do_load) begin
         quo_ff <= numframe;
         rem_ff <= '0;
         cnt_ff <= 5'(PER_W - 1);
      end else if (do_div) begin
         if (rem_sh >= reps_ext) begin
            rem_ff <= rem_sh - reps_ext;
            quo_ff <= {quo_ff[PER_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[PER_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 5'd1;
      end
      if (do_mul) begin
         per_ff <= quo_ff;
         rp_ff <= prod[PER_W-1:0];
      end
   end

   always_comb begin
      cfg.span_start = start_ff;
      cfg.span_end = end_ff;
      cfg.peak_frame = peak_ff;
      cfg.total_frames = total_ff;
      cfg.repeat_count = reps_ff;
      cfg.mirror_position = mpos_ff;
      cfg.mirror_sign = msign_ff;
      cfg.half_offset = half_ff;
      cfg.period = per_ff;
      cfg.rep_total = rp_ff;
      cfg.err = !(end_ff >= start_ff && peak_ff >= start_ff && peak_ff <= end_ff &&
                  total_ff > end_ff && reps_ff >= REPS_W'(1) &&
                  reps_ff <= REPS_W'(MAX_REPS));
   end

endmodule

[src/rceg_front.sv]
// front: takes frames, finds the repeat and classifies the curve segment
module rceg_front (
   input  logic clock,
   input  logic reset,
   input  rceg_pkg::cfg_type cfg,
   input  logic busy,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,
   output logic job_valid,
   input  logic job_ready,
   output rceg_pkg::job_type job
);
   import rceg_pkg::*;

   typedef struct packed {
      logic err;
      logic oot;
      logic active;
      logic short_per;
      logic le;
      logic inr;
      logic [PER_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } fdiv_type;

   typedef struct packed {
      logic err;
      logic oot;
      logic active;
      logic short_per;
      logic le;
      logic inr;
      logic first;
      logic last;
      logic minus;
      logic div2;
      logic [PER_W-1:0] fs;
      logic [DEN_W-1:0] aoff;
   } fmid_type;

   localparam int SH_W = PER_W + QUO_W - 1;

   logic en;
   logic a_valid_ff, a_oot_ff, a_ge_ff, a_le_ff;
   logic [FRAME_W-1:0] a_d_ff;
   logic [FRAME_W-1:0] f;
   logic dv_valid_ff [0:QUO_W];
   fdiv_type dv_ff [0:QUO_W];
   fdiv_type dv_in [0:QUO_W];
   logic m_valid_ff, c_valid_ff;
   fmid_type m_ff, m_in;
   job_type c_ff, c_in;
   logic clip;
   logic [REPS_W-1:0] r;
   logic [FRAME_W-1:0] off;
   logic signed [DEN_W-1:0] fs_s, per_s, aoff_s;

   assign en = !c_valid_ff || job_ready;
   assign req_tready = en && !busy;
   assign f = req_tdata[FRAME_W-1:0];
   assign job_valid = c_valid_ff;
   assign job = c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         for (int k = 0; k <= QUO_W; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         m_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid && !busy;
         dv_valid_ff[0] <= a_valid_ff;
         for (int k = 0; k < QUO_W; k++) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
         m_valid_ff <= dv_valid_ff[QUO_W];
         c_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_oot_ff <= f >= cfg.total_frames;
         a_ge_ff <= f >= cfg.span_start;
         a_le_ff <= f <= cfg.span_end;
         a_d_ff <= f - cfg.span_start;
         for (int k = 0; k <= QUO_W; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         m_ff <= m_in;
         c_ff <= c_in;
      end
   end

   // one quotient bit of frame offset / period per stage
   always_comb begin
      logic [SH_W-1:0] rem_x;
      logic [SH_W-1:0] sh;
      dv_in[0].err = cfg.err;
      dv_in[0].oot = a_oot_ff;
      dv_in[0].active = !cfg.err && !a_oot_ff && a_ge_ff;
      dv_in[0].short_per = cfg.period < PER_W'(3);
      dv_in[0].le = a_le_ff;
      dv_in[0].inr = {1'b0, a_d_ff} <= cfg.rep_total;
      dv_in[0].rem = {1'b0, a_d_ff};
      dv_in[0].quo = '0;
      for (int k = 0; k < QUO_W; k++) begin
         dv_in[k+1] = dv_ff[k];
         rem_x = {{(SH_W-PER_W){1'b0}}, dv_ff[k].rem};
         sh = {{(SH_W-PER_W){1'b0}}, cfg.period} << (QUO_W - 1 - k);
         if (rem_x >= sh) begin
            dv_in[k+1].rem = PER_W'(rem_x - sh);
            dv_in[k+1].quo[QUO_W-1-k] = 1'b1;
         end
      end
   end

   assign clip = dv_ff[QUO_W].quo >= cfg.repeat_count;
   assign r = clip ? cfg.repeat_count - REPS_W'(1) : dv_ff[QUO_W].quo;
   assign off = cfg.peak_frame - cfg.span_start;

   always_comb begin
      m_in.err = dv_ff[QUO_W].err;
      m_in.oot = dv_ff[QUO_W].oot;
      m_in.active = dv_ff[QUO_W].active;
      m_in.short_per = dv_ff[QUO_W].short_per;
      m_in.le = dv_ff[QUO_W].le;
      m_in.inr = dv_ff[QUO_W].inr;
      m_in.first = r == '0;
      m_in.last = r == cfg.repeat_count - REPS_W'(1);
      m_in.minus = cfg.mirror_sign && r[0];
      m_in.div2 = cfg.mirror_sign && cfg.half_offset;
      m_in.fs = clip ? cfg.period : dv_ff[QUO_W].rem;
      if (cfg.mirror_position && r[0]) begin
         m_in.aoff = {1'b0, cfg.period} - {2'b0, off};
      end else begin
         m_in.aoff = {2'b0, off};
      end
   end

   assign fs_s = $signed({1'b0, m_ff.fs});
   assign per_s = $signed({1'b0, cfg.period});
   assign aoff_s = $signed(m_ff.aoff);

   always_comb begin
      c_in.kind = K_ZERO;
      c_in.minus = m_ff.minus;
      c_in.div2 = m_ff.div2;
      c_in.err = m_ff.err;
      c_in.oot = m_ff.oot;
      c_in.num = m_ff.fs;
      c_in.den = m_ff.aoff;
      if (!m_ff.active) begin
         c_in.kind = K_ZERO;
      end else if (m_ff.short_per) begin
         c_in.kind = m_ff.le ? K_ONE : K_ZERO;
      end else if (!m_ff.inr) begin
         c_in.kind = K_ZERO;
      end else if (fs_s == '0 && fs_s != aoff_s) begin
         c_in.kind = (!m_ff.first && m_ff.div2) ? K_HALF : K_ZERO;
      end else if (fs_s == per_s && fs_s != aoff_s) begin
         c_in.kind = (!m_ff.last && m_ff.div2) ? K_HALF : K_ZERO;
      end else if (fs_s < aoff_s) begin
         c_in.kind = m_ff.first ? K_PLAIN : K_SIGNED;
      end else if (fs_s > aoff_s) begin
         c_in.num = cfg.period - m_ff.fs;
         c_in.den = DEN_W'(per_s - aoff_s);
         if (m_ff.last && m_ff.div2) begin
            c_in.kind = m_ff.minus ? K_ZERO : K_PLAIN;
         end else begin
            c_in.kind = K_SIGNED;
         end
      end else if (m_ff.div2) begin
         c_in.kind = m_ff.minus ? K_ZERO : K_ONE;
      end else begin
         c_in.kind = m_ff.minus ? K_NEG_ONE : K_ONE;
      end
   end

endmodule

[src/rceg_queue.sv]
// short item queue between front and back
module rceg_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  rceg_pkg::job_type push_data,
   output logic pop_valid,
   input  logic pop,
   output rceg_pkg::job_type pop_data
);
   import rceg_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type slot_ff [0:QUEUE_DEPTH-1];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0] cnt_ff;
   logic do_push, do_pop;

   assign push_ready = cnt_ff != (PTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_data = slot_ff[rd_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + (PTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - (PTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[src/rceg_back.sv]
// back: table index division, rise table lookup and final weight mapping
module rceg_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_pop,
   input  rceg_pkg::job_type job,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic [1:0] rsp_tuser
);
   import rceg_pkg::*;

   localparam rise_tab_type RISE_TAB = build_rise_tab();
   localparam int CMP_W = DIVD_W + 1;

   typedef struct packed {
      kind_type kind;
      logic minus;
      logic div2;
      logic err;
      logic oot;
      logic [DEN_W-1:0] den;
      logic [DIVD_W-1:0] rem;
      logic [IDX_W-1:0] quo;
   } bdiv_type;

   logic en;
   logic bv_ff [0:IDX_W];
   bdiv_type bd_ff [0:IDX_W];
   bdiv_type bd_in [0:IDX_W];
   logic t_valid_ff;
   logic [TAB_W-1:0] t_val_ff;
   kind_type t_kind_ff;
   logic t_minus_ff, t_div2_ff, t_err_ff, t_oot_ff;
   logic [IDX_W-1:0] idx;
   logic o_valid_ff;
   logic [WEIGHT_W-1:0] o_w_ff, w_in;
   logic o_err_ff, o_oot_ff;
   logic signed [WEIGHT_W:0] sv;
   logic signed [WEIGHT_W:0] hv;

   assign en = !o_valid_ff || rsp_tready;
   assign job_pop = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= IDX_W; k++) begin
            bv_ff[k] <= 1'b0;
         end
         t_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         bv_ff[0] <= job_valid;
         for (int k = 0; k < IDX_W; k++) begin
            bv_ff[k+1] <= bv_ff[k];
         end
         t_valid_ff <= bv_ff[IDX_W];
         o_valid_ff <= t_valid_ff;
      end
   end

   // rounded num * depth / den, one quotient bit per stage
   always_comb begin
      logic [CMP_W-1:0] rem_x;
      logic [CMP_W-1:0] sh;
      bd_in[0].kind = job.kind;
      bd_in[0].minus = job.minus;
      bd_in[0].div2 = job.div2;
      bd_in[0].err = job.err;
      bd_in[0].oot = job.oot;
      bd_in[0].den = job.den;
      bd_in[0].rem = ({{(DIVD_W-NUM_W){1'b0}}, job.num} << (IDX_W - 1)) +
                     {{(DIVD_W-DEN_W+1){1'b0}}, job.den[DEN_W-1:1]};
      bd_in[0].quo = '0;
      for (int k = 0; k < IDX_W; k++) begin
         bd_in[k+1] = bd_ff[k];
         rem_x = {1'b0, bd_ff[k].rem};
         sh = {{(CMP_W-DEN_W){1'b0}}, bd_ff[k].den} << (IDX_W - 1 - k);
         if (rem_x >= sh) begin
            bd_in[k+1].rem = DIVD_W'(rem_x - sh);
            bd_in[k+1].quo[IDX_W-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= IDX_W; k++) begin
            bd_ff[k] <= bd_in[k];
         end
      end
   end

   assign idx = (bd_ff[IDX_W].quo > IDX_W'(COS_DEPTH)) ? IDX_W'(COS_DEPTH) :
                bd_ff[IDX_W].quo;

   always_ff @(posedge clock) begin
      if (en) begin
         t_val_ff <= RISE_TAB[idx];
         t_kind_ff <= bd_ff[IDX_W].kind;
         t_minus_ff <= bd_ff[IDX_W].minus;
         t_div2_ff <= bd_ff[IDX_W].div2;
         t_err_ff <= bd_ff[IDX_W].err;
         t_oot_ff <= bd_ff[IDX_W].oot;
      end
   end

   assign sv = t_minus_ff ? -$signed({2'b0, t_val_ff}) : $signed({2'b0, t_val_ff});
   assign hv = (sv + $signed((WEIGHT_W+1)'(ONE_Q16))) >>> 1;

   always_comb begin
      case (t_kind_ff)
         K_ZERO: w_in = '0;
         K_ONE: w_in = WEIGHT_W'(ONE_Q16);
         K_NEG_ONE: w_in = -WEIGHT_W'(ONE_Q16);
         K_HALF: w_in = WEIGHT_W'(ONE_Q16 >> 1);
         K_PLAIN: w_in = {1'b0, t_val_ff};
         K_SIGNED: w_in = t_div2_ff ? hv[WEIGHT_W-1:0] : sv[WEIGHT_W-1:0];
         default: w_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_w_ff <= w_in;
         o_err_ff <= t_err_ff;
         o_oot_ff <= t_oot_ff;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = {{(24-WEIGHT_W){1'b0}}, o_w_ff};
   assign rsp_tuser = {o_oot_ff, o_err_ff};

endmodule

[src/repeated_cosine_envelope_generator_unit.sv]
// top level of the repeated cosine envelope generator
// Each frame index item yields one weight item, in order, one item per clock when neither side
// stalls and the period is not being recomputed; a result passes the repeat-index divider of the
// front (seven stages), the item queue, the table-index divider of the back (eleven stages) and
// the rise table read. After every configuration write, and after reset, the derived repeat period
// is recomputed by a serial divider, and while it runs no frame item is accepted.
module repeated_cosine_envelope_generator_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,   // frame_index
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,   // weight[17:0], zero fill
   output logic [1:0] rsp_tuser,    // [1] out_of_track, [0] settings_error
   input  logic csr_tvalid,
   output logic csr_tready,
   input  logic [rceg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rceg_pkg::CSR_DATA_W-1:0] csr_data
);
   import rceg_pkg::*;

   cfg_type cfg;
   logic busy;
   logic f_valid, f_ready;
   job_type f_job;
   logic q_valid, q_pop;
   job_type q_job;

   rceg_cfg u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_tvalid(csr_tvalid),
      .csr_tready(csr_tready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg),
      .busy(busy)
   );

   rceg_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .busy(busy),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .job_valid(f_valid),
      .job_ready(f_ready),
      .job(f_job)
   );

   rceg_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data(f_job),
      .pop_valid(q_valid),
      .pop(q_pop),
      .pop_data(q_job)
   );

   rceg_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(q_valid),
      .job_pop(q_pop),
      .job(q_job),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule

[sim/testbench.sv]
// self-checking testbench for the repeated cosine envelope generator unit
`timescale 1ns / 1ps

module testbench;
   import rceg_pkg::*;

   typedef struct {
      logic signed [17:0] weight;
      logic settings_error;
      logic out_of_track;
   } weight_item_type;

   class envelope_scoreboard;
      int unsigned span_start, span_end, peak_frame, total_frames, repeat_count;
      bit mirror_position, mirror_sign, half_offset;
      int unsigned rise_lut [0:1024];
      weight_item_type expected_weights [$];
      int errors;

      function new();
         longint unsigned phi, s, w;
         for (int k = 0; k <= 1024; k++) begin
            phi = (64'd3373259426 * longint'(k)) / 64'd2048;
            s = sin_q30(phi);
            w = (s * s + (64'd1 << 43)) >> 44;
            if (w > 64'd65536) begin
               w = 64'd65536;
            end
            rise_lut[k] = w;
         end
         reset_regs();
         errors = 0;
      endfunction

      function longint unsigned sin_q30(longint unsigned phi);
         longint unsigned p2, term, sum;
         p2 = (phi * phi) >> 30;
         term = phi;
         sum = phi;
         for (int n = 1; n <= 8; n++) begin
            term = ((term * p2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum > 64'd1073741824) begin
            sum = 64'd1073741824;
         end
         return sum;
      endfunction

      function void reset_regs();
         span_start = 0;
         span_end = 0;
         peak_frame = 0;
         total_frames = 1;
         repeat_count = 1;
         mirror_position = 0;
         mirror_sign = 0;
         half_offset = 0;
      endfunction

      function void write_reg(csr_addr_type idx, logic [15:0] v);
         case (idx)
            REG_SPAN_START: span_start = v;
            REG_SPAN_END: span_end = v;
            REG_PEAK_FRAME: peak_frame = v;
            REG_TOTAL_FRAMES: total_frames = v;
            REG_REPEAT_COUNT: repeat_count = v[6:0];
            REG_MIRROR_POSITION: mirror_position = v[0];
            REG_MIRROR_SIGN: mirror_sign = v[0];
            REG_HALF_OFFSET: half_offset = v[0];
            default: ;
         endcase
      endfunction

      function int rise(int num, int den);
         longint idx;
         if (den <= 0 || num < 0) begin
            return 0;
         end
         idx = (longint'(num) * 1024 + den / 2) / den;
         if (idx > 1024) begin
            idx = 1024;
         end
         return rise_lut[idx];
      endfunction

      function int halve_up(int w);
         return (w + 65536) >>> 1;
      endfunction

      function void note_frame(logic [15:0] frame);
         weight_item_type item;
         int f, st, reps, per, d, r, s, e, a, off, v, w;
         bit err, oot, odd, minus, div2, first, last;
         f = frame;
         w = 0;
         err = !(span_end >= span_start && peak_frame >= span_start &&
                 peak_frame <= span_end && total_frames > span_end &&
                 repeat_count >= 1 && repeat_count <= 100);
         oot = f >= total_frames;
         if (!err && !oot && f >= span_start) begin
            st = span_start;
            reps = repeat_count;
            per = (int'(span_end) - st + 1) / reps;
            d = f - st;
            if (per < 3) begin
               w = (f <= span_end) ? 65536 : 0;
            end else if (d <= reps * per) begin
               r = d / per;
               if (r >= reps) begin
                  r = reps - 1;
               end
               s = st + r * per;
               e = s + per;
               off = int'(peak_frame) - st;
               odd = r % 2;
               a = (mirror_position && odd) ? s + per - off : s + off;
               minus = mirror_sign && odd;
               div2 = mirror_sign && half_offset;
               first = (r == 0);
               last = (r == reps - 1);
               if (f == s && f != a) begin
                  w = (!first && div2) ? 32768 : 0;
               end else if (f == e && f != a) begin
                  w = (!last && div2) ? 32768 : 0;
               end else if (f < a) begin
                  v = rise(f - s, a - s);
                  if (first) begin
                     w = v;
                  end else begin
                     w = minus ? -v : v;
                     if (div2) begin
                        w = halve_up(w);
                     end
                  end
               end else if (f > a) begin
                  v = rise(e - f, e - a);
                  if (last && div2) begin
                     w = minus ? 0 : v;
                  end else begin
                     w = minus ? -v : v;
                     if (div2) begin
                        w = halve_up(w);
                     end
                  end
               end else begin
                  w = minus ? -65536 : 65536;
                  if (div2) begin
                     w = halve_up(w);
                  end
               end
            end
         end
         item.weight = w;
         item.settings_error = err;
         item.out_of_track = oot;
         expected_weights.push_back(item);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_weight(logic [17:0] weight, logic settings_error, logic out_of_track);
         weight_item_type item;
         if (expected_weights.size() == 0) begin
            report("weight item with none expected");
            return;
         end
         item = expected_weights.pop_front();
         if (weight !== item.weight) begin
            report($sformatf("weight %0d, expected %0d", $signed(weight), item.weight));
         end
         if (settings_error !== item.settings_error) begin
            report($sformatf("settings_error %b, expected %b", settings_error,
                             item.settings_error));
         end
         if (out_of_track !== item.out_of_track) begin
            report($sformatf("out_of_track %b, expected %b", out_of_track,
                             item.out_of_track));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [15:0] req_tdata = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_tvalid = 0;
   logic csr_tready;
   logic [CSR_IDX_W-1:0] csr_index = REG_SPAN_START;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   envelope_scoreboard sb = new();
   bit quiet = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int probe_frames [13] = '{9, 10, 11, 60, 109, 110, 111, 209, 210, 309, 310, 399, 400};

   repeated_cosine_envelope_generator_unit dut (.*);

   always #4 clock = ~clock;

   // weight side with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_weight(rsp_tdata[17:0], rsp_tuser[0], rsp_tuser[1]);
      end
      if (reset || quiet) begin
         rsp_tready <= !reset;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= 3000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task write_csr(csr_addr_type idx, logic [15:0] v);
      csr_tvalid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_tready);
      sb.write_reg(idx, v);
   endtask

   task configure(int st, int en, int pk, int tot, int reps, bit mp, bit ms, bit ho);
      write_csr(REG_SPAN_START, st);
      write_csr(REG_SPAN_END, en);
      write_csr(REG_PEAK_FRAME, pk);
      write_csr(REG_TOTAL_FRAMES, tot);
      write_csr(REG_REPEAT_COUNT, reps);
      write_csr(REG_MIRROR_POSITION, mp);
      write_csr(REG_MIRROR_SIGN, ms);
      write_csr(REG_HALF_OFFSET, ho);
      csr_tvalid <= 0;
   endtask

   task send_frame(logic [15:0] f);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= f;
      do @(posedge clock); while (!req_tready);
      sb.note_frame(f);
   endtask

   task drain();
      req_tvalid <= 0;
      wait (sb.expected_weights.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   // mostly frames around the span, some anywhere in the frame index range
   task send_random_frames(int n);
      int lo, hi;
      lo = (sb.span_start > 4) ? sb.span_start - 4 : 0;
      hi = (sb.span_end < 65531) ? sb.span_end + 4 : 65535;
      if (hi < lo) begin
         hi = lo + 8;
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            send_frame($urandom_range(lo, hi));
         end else begin
            send_frame($urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      int st, en, pk;
      repeat (12) @(posedge clock);
      reset <= 0;

      // reset settings
      send_frame(0);
      send_frame(1);
      send_frame(16'hffff);
      drain();

      configure(10, 309, 60, 400, 3, 0, 0, 0);
      foreach (probe_frames[i]) begin
         send_frame(16'(probe_frames[i]));
      end
      drain();

      configure(10, 309, 30, 400, 4, 1, 1, 1);
      send_frame(10);
      send_frame(30);
      send_frame(84);
      send_frame(138);
      send_frame(200);
      send_frame(306);
      send_frame(308);
      send_random_frames(30);
      drain();

      // short period
      configure(5, 12, 7, 20, 5, 0, 0, 0);
      send_random_frames(12);
      drain();

      // invalid settings
      configure(50, 40, 45, 60, 1, 0, 0, 0);
      send_frame(45);
      send_frame(70);
      drain();
      configure(0, 100, 10, 200, 0, 0, 0, 0);
      send_frame(10);
      drain();
      configure(0, 100, 10, 200, 127, 0, 0, 0);
      send_frame(10);
      drain();

      // widest span, peak beyond the period
      configure(0, 65534, 65534, 65535, 100, 1, 1, 0);
      send_frame(0);
      send_frame(655);
      send_frame(65534);
      send_random_frames(30);
      drain();

      configure(0, 65534, 0, 65535, 7, 0, 1, 1);
      send_random_frames(30);
      drain();

      configure(100, 499, 100, 600, 7, 1, 0, 1);
      send_random_frames(25);
      drain();

      for (int p = 0; p < 6; p++) begin
         if (p >= 4) begin
            quiet = 1;
         end
         if (p == 3) begin
            configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 127), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 1));
         end else begin
            st = $urandom_range(0, 30000);
            en = st + $urandom_range(0, 3000);
            pk = $urandom_range(st, en);
            configure(st, en, pk, en + 1 + $urandom_range(0, 200), $urandom_range(1, 100),
                      $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
         end
         send_random_frames(40);
         drain();
      end

      if (sb.expected_weights.size() != 0) begin
         sb.report("weight items never arrived");
      end
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
